// File: rtl/sec_pkg.sv
// package for the equivalent source combiner
// widths, codes, micro-program table and saturation helpers; no dependencies
package sec_pkg;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int PW = 2 * DW;
  localparam int QB = DW - 1;
  localparam int IB = QB - FB;
  localparam int CW = $clog2(QB + 1);
  localparam int IN_W = 6 * DW;
  localparam int IN_UW = 4;
  localparam int OUT_UW = 6;

  typedef logic signed [DW-1:0] word_t;
  typedef logic signed [PW-1:0] wide_t;
  typedef struct packed {
    word_t re;
    word_t im;
  } cx_t;

  typedef enum logic [2:0] {
    CMD_LOAD = 3'd0,
    CMD_PAR  = 3'd1,
    CMD_SER  = 3'd2,
    CMD_APV  = 3'd3,
    CMD_API  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ERR_OK     = 3'd0,
    ERR_VCONF  = 3'd1,
    ERR_CCONF  = 3'd2,
    ERR_ZIMP   = 3'd3,
    ERR_INFIMP = 3'd4,
    ERR_DIV0   = 3'd5
  } err_t;

  typedef enum logic [2:0] {
    OP_END,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  typedef enum logic [3:0] {
    R_ZERO,
    R_Z,
    R_C,
    R_EZ,
    R_EC,
    R_DR,
    R_T,
    R_S,
    R_N,
    R_A
  } sel_t;

  typedef enum logic [3:0] {
    P_NONE,
    P_LOAD,
    P_PAR_CC,
    P_PAR_CE,
    P_PAR_EC,
    P_PAR_EE,
    P_SER_EC,
    P_SER_EE,
    P_APV_C,
    P_APV_E,
    P_API_E
  } prog_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FETCH,
    ST_ADD,
    ST_MAC,
    ST_DCHK,
    ST_DSTART,
    ST_DWAIT,
    ST_WB,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t  op;
    sel_t dst;
    sel_t a;
    sel_t b;
  } uop_t;

  function automatic uop_t mk(op_t op, sel_t dst, sel_t a, sel_t b);
    uop_t u;
    u.op = op;
    u.dst = dst;
    u.a = a;
    u.b = b;
    return u;
  endfunction

  localparam uop_t U_END = '{op: OP_END, dst: R_ZERO, a: R_ZERO, b: R_ZERO};

  // micro-program store, one sequence per command case; P_LOAD and P_SER_EC share one
  function automatic uop_t fetch(prog_t p, logic [2:0] pc);
    uop_t u;
    u = U_END;
    case (p)
      P_LOAD, P_SER_EC: begin
        case (pc)
          3'd0: u = mk(OP_ADD, R_Z, R_EZ, R_ZERO);
          3'd1: u = mk(OP_ADD, R_C, R_EC, R_ZERO);
          default: u = U_END;
        endcase
      end
      P_PAR_CC: begin
        case (pc)
          3'd0: u = mk(OP_ADD, R_C, R_C, R_EC);
          default: u = U_END;
        endcase
      end
      P_PAR_CE: begin
        case (pc)
          3'd0: u = mk(OP_MUL, R_T, R_C, R_EZ);
          3'd1: u = mk(OP_ADD, R_C, R_T, R_EC);
          3'd2: u = mk(OP_ADD, R_Z, R_EZ, R_ZERO);
          default: u = U_END;
        endcase
      end
      P_PAR_EC: begin
        case (pc)
          3'd0: u = mk(OP_MUL, R_T, R_EC, R_Z);
          3'd1: u = mk(OP_ADD, R_C, R_C, R_T);
          default: u = U_END;
        endcase
      end
      P_PAR_EE: begin
        case (pc)
          3'd0: u = mk(OP_ADD, R_S, R_Z, R_EZ);
          3'd1: u = mk(OP_MUL, R_T, R_C, R_EZ);
          3'd2: u = mk(OP_MUL, R_N, R_EC, R_Z);
          3'd3: u = mk(OP_ADD, R_N, R_T, R_N);
          3'd4: u = mk(OP_DIV, R_C, R_N, R_S);
          3'd5: u = mk(OP_DIV, R_T, R_EZ, R_S);
          3'd6: u = mk(OP_MUL, R_Z, R_Z, R_T);
          default: u = U_END;
        endcase
      end
      P_SER_EE: begin
        case (pc)
          3'd0: u = mk(OP_ADD, R_Z, R_Z, R_EZ);
          3'd1: u = mk(OP_ADD, R_C, R_C, R_EC);
          default: u = U_END;
        endcase
      end
      P_APV_C: begin
        case (pc)
          3'd0: u = mk(OP_ADD, R_A, R_C, R_ZERO);
          default: u = U_END;
        endcase
      end
      P_APV_E: begin
        case (pc)
          3'd0: u = mk(OP_SUB, R_T, R_C, R_DR);
          3'd1: u = mk(OP_DIV, R_A, R_T, R_Z);
          default: u = U_END;
        endcase
      end
      P_API_E: begin
        case (pc)
          3'd0: u = mk(OP_MUL, R_T, R_DR, R_Z);
          3'd1: u = mk(OP_SUB, R_A, R_C, R_T);
          default: u = U_END;
        endcase
      end
      default: u = U_END;
    endcase
    return u;
  endfunction

  function automatic wide_t sx(word_t x);
    return {{(PW-DW){x[DW-1]}}, x};
  endfunction

  // clamp a wide signed value into the word range
  function automatic word_t sat_dw(wide_t v);
    word_t r;
    if ((&v[PW-1:DW-1]) || !(|v[PW-1:DW-1])) begin
      r = v[DW-1:0];
    end else if (v[PW-1]) begin
      r = {1'b1, {(DW-1){1'b0}}};
    end else begin
      r = {1'b0, {(DW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// File: rtl/sec_mul.sv
// registered signed multiplier shared by all products
// depends on sec_pkg
module sec_mul (
  input  logic           clk,
  input  sec_pkg::word_t a,
  input  sec_pkg::word_t b,
  output sec_pkg::wide_t p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// File: rtl/sec_div.sv
// restoring divider, one quotient bit per cycle, with overflow detect
// depends on sec_pkg
module sec_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [sec_pkg::PW-1:0] mag,
  input  logic [sec_pkg::PW-1:0] den,
  output logic                   done,
  output logic                   sat,
  output logic [sec_pkg::QB-1:0] quo
);

  logic                   busy;
  logic [sec_pkg::CW-1:0] cnt;
  logic [sec_pkg::PW-1:0] rem;
  logic [sec_pkg::QB-1:0] shf;
  logic [sec_pkg::PW:0]   r2;
  logic [sec_pkg::PW-1:0] head;

  assign head = mag >> sec_pkg::IB;
  assign r2 = {rem, shf[sec_pkg::QB-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // integer part would not fit the result word
        if (head >= den) begin
          sat  <= 1'b1;
          done <= 1'b1;
        end else begin
          sat  <= 1'b0;
          busy <= 1'b1;
          rem  <= head;
          shf  <= {mag[sec_pkg::IB-1:0], {sec_pkg::FB{1'b0}}};
          quo  <= '0;
          cnt  <= '0;
        end
      end else if (busy) begin
        if (r2 >= {1'b0, den}) begin
          rem <= sec_pkg::PW'(r2 - {1'b0, den});
          quo <= {quo[sec_pkg::QB-2:0], 1'b1};
        end else begin
          rem <= r2[sec_pkg::PW-1:0];
          quo <= {quo[sec_pkg::QB-2:0], 1'b0};
        end
        shf <= {shf[sec_pkg::QB-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == sec_pkg::CW'(sec_pkg::QB - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/source_equivalent_combiner_unit.sv
// top level of the equivalent source combiner: sequencer, operand registers, state
// depends on sec_pkg, sec_mul, sec_div
//
// channel   dir  signals                      content
// s_*       in   tvalid tready tdata tuser    one command with element and drive
// m_*       out  tvalid tready tdata tuser    kept source, answer, flags, error
//
// micro-ops of a transaction run one at a time, each fetched and then written back; a
// product runs on the single multiplier and a quotient takes two divider runs (one per
// part, 31 quotient bits each, ending early when it saturates);
// parallel merge of two emf sources is longest.
// rst is synchronous; it restores the unit current source of zero value.
// s_tready is high only while idle; a finished result waits in the output register,
// and the next transaction is taken while it waits.
module source_equivalent_combiner_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // elem_z_re, elem_z_im, elem_c_re, elem_c_im, drive_re, drive_im
  input  logic [sec_pkg::IN_W-1:0]     s_tdata,
  // cmd[2:0], elem_is_emf[3]
  input  logic [sec_pkg::IN_UW-1:0]    s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // acc_imp_re, acc_imp_im, acc_src_re, acc_src_im, answer_re, answer_im
  output logic [sec_pkg::IN_W-1:0]     m_tdata,
  // acc_kind[0], fixed_voltage[1], fixed_current[2], error_code[5:3]
  output logic [sec_pkg::OUT_UW-1:0]   m_tuser
);

  localparam int DW = sec_pkg::DW;
  localparam int PW = sec_pkg::PW;

  sec_pkg::state_t state, state_next;
  logic            kind;
  sec_pkg::cx_t    imp, src;
  logic            ek, wk;
  logic [2:0]      cmdr;
  sec_pkg::err_t   err;
  sec_pkg::prog_t  prog;
  logic [2:0]      pc;
  sec_pkg::uop_t   cur, uop_f;
  sec_pkg::cx_t    rz, rc, rez, rec, rdr, rt, rs, rn, ra, resv;
  sec_pkg::cx_t    opa, opb, wbv;
  logic [2:0]      mcnt, midx, nsteps;
  logic [PW-1:0]   acc0, acc1, acc2;
  sec_pkg::word_t  mx, my;
  sec_pkg::wide_t  prod;
  logic [PW-1:0]   sh;
  logic            dcomp, dneg, dneg_c;
  logic [PW-1:0]   du, dmag;
  logic            div_start, div_done, div_sat;
  logic [sec_pkg::QB-1:0] div_quo;
  sec_pkg::word_t  dval;
  sec_pkg::wide_t  qx;
  sec_pkg::prog_t  dec_prog;
  sec_pkg::err_t   dec_err;
  logic            dec_wk;
  logic            zz, ezz, out_go;
  logic            nk;
  sec_pkg::cx_t    nz, nc;

  sec_mul u_mul (.clk(clk), .a(mx), .b(my), .p(prod));

  sec_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .mag(dmag), .den(acc2),
    .done(div_done), .sat(div_sat), .quo(div_quo)
  );

  assign uop_f = sec_pkg::fetch(prog, pc);
  assign zz = (imp == '0);
  assign ezz = (rez == '0);
  assign nsteps = (cur.op == sec_pkg::OP_MUL) ? 3'd4 : 3'd6;
  assign midx = mcnt - 3'd1;
  assign sh = prod >>> sec_pkg::FB;
  assign out_go = !m_tvalid || m_tready;

  // operand read
  always_comb begin
    case (cur.a)
      sec_pkg::R_Z:  opa = rz;
      sec_pkg::R_C:  opa = rc;
      sec_pkg::R_EZ: opa = rez;
      sec_pkg::R_EC: opa = rec;
      sec_pkg::R_DR: opa = rdr;
      sec_pkg::R_T:  opa = rt;
      sec_pkg::R_S:  opa = rs;
      sec_pkg::R_N:  opa = rn;
      sec_pkg::R_A:  opa = ra;
      default:       opa = '0;
    endcase
    case (cur.b)
      sec_pkg::R_Z:  opb = rz;
      sec_pkg::R_C:  opb = rc;
      sec_pkg::R_EZ: opb = rez;
      sec_pkg::R_EC: opb = rec;
      sec_pkg::R_DR: opb = rdr;
      sec_pkg::R_T:  opb = rt;
      sec_pkg::R_S:  opb = rs;
      sec_pkg::R_N:  opb = rn;
      sec_pkg::R_A:  opb = ra;
      default:       opb = '0;
    endcase
  end

  // multiplier operand schedule
  always_comb begin
    mx = opa.re;
    my = opb.re;
    if (cur.op == sec_pkg::OP_MUL) begin
      case (mcnt)
        3'd1: begin mx = opa.im; my = opb.im; end
        3'd2: begin mx = opa.re; my = opb.im; end
        3'd3: begin mx = opa.im; my = opb.re; end
        default: begin mx = opa.re; my = opb.re; end
      endcase
    end else begin
      // denominator first, then the two numerator parts
      case (mcnt)
        3'd0: begin mx = opb.re; my = opb.re; end
        3'd1: begin mx = opb.im; my = opb.im; end
        3'd2: begin mx = opa.re; my = opb.re; end
        3'd3: begin mx = opa.im; my = opb.im; end
        3'd4: begin mx = opa.im; my = opb.re; end
        default: begin mx = opa.re; my = opb.im; end
      endcase
    end
  end

  // sign and magnitude of the numerator going to the divider
  always_comb begin
    du = dcomp ? acc1 : acc0;
    dneg_c = du > {1'b1, {(PW-1){1'b0}}};
    dmag = dneg_c ? (~du + 1'b1) : du;
    qx = {{(PW-sec_pkg::QB){1'b0}}, div_quo};
    if (div_sat) begin
      dval = dneg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      dval = dneg ? sec_pkg::sat_dw(-qx) : sec_pkg::sat_dw(qx);
    end
  end

  always_comb begin
    if (cur.op == sec_pkg::OP_MUL) begin
      wbv.re = sec_pkg::sat_dw($signed(acc0));
      wbv.im = sec_pkg::sat_dw($signed(acc1));
    end else begin
      wbv = resv;
    end
  end

  // command decode against the kept source
  always_comb begin
    dec_prog = sec_pkg::P_NONE;
    dec_err = sec_pkg::ERR_OK;
    dec_wk = kind;
    case (cmdr)
      sec_pkg::CMD_LOAD: begin
        dec_prog = sec_pkg::P_LOAD;
        dec_wk = ek;
      end
      sec_pkg::CMD_PAR: begin
        case ({kind, ek})
          2'b00: dec_prog = sec_pkg::P_PAR_CC;
          2'b01: begin
            dec_prog = sec_pkg::P_PAR_CE;
            dec_wk = 1'b1;
          end
          2'b10: dec_prog = sec_pkg::P_PAR_EC;
          default: begin
            if (zz && ezz) dec_err = sec_pkg::ERR_VCONF;
            else dec_prog = sec_pkg::P_PAR_EE;
          end
        endcase
      end
      sec_pkg::CMD_SER: begin
        case ({kind, ek})
          2'b00: dec_err = sec_pkg::ERR_CCONF;
          2'b10: begin
            dec_prog = sec_pkg::P_SER_EC;
            dec_wk = 1'b0;
          end
          2'b11: dec_prog = sec_pkg::P_SER_EE;
          default: dec_prog = sec_pkg::P_NONE;
        endcase
      end
      sec_pkg::CMD_APV: begin
        if (!kind) dec_prog = sec_pkg::P_APV_C;
        else if (zz) dec_err = sec_pkg::ERR_ZIMP;
        else dec_prog = sec_pkg::P_APV_E;
      end
      sec_pkg::CMD_API: begin
        if (!kind) dec_err = sec_pkg::ERR_INFIMP;
        else dec_prog = sec_pkg::P_API_E;
      end
      default: dec_prog = sec_pkg::P_NONE;
    endcase
  end

  // state after commit, as reported
  always_comb begin
    if (err == sec_pkg::ERR_OK) begin
      nk = wk;
      nz = rz;
      nc = rc;
    end else begin
      nk = kind;
      nz = imp;
      nc = src;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sec_pkg::ST_IDLE:   if (s_tvalid) state_next = sec_pkg::ST_DECODE;
      sec_pkg::ST_DECODE: state_next = sec_pkg::ST_FETCH;
      sec_pkg::ST_FETCH: begin
        case (uop_f.op)
          sec_pkg::OP_ADD, sec_pkg::OP_SUB: state_next = sec_pkg::ST_ADD;
          sec_pkg::OP_MUL, sec_pkg::OP_DIV: state_next = sec_pkg::ST_MAC;
          default: state_next = sec_pkg::ST_DONE;
        endcase
      end
      sec_pkg::ST_ADD: state_next = sec_pkg::ST_WB;
      sec_pkg::ST_MAC: begin
        if (mcnt == nsteps) begin
          state_next = (cur.op == sec_pkg::OP_MUL) ? sec_pkg::ST_WB : sec_pkg::ST_DCHK;
        end
      end
      sec_pkg::ST_DCHK:
        state_next = (acc2 == '0) ? sec_pkg::ST_DONE : sec_pkg::ST_DSTART;
      sec_pkg::ST_DSTART: state_next = sec_pkg::ST_DWAIT;
      sec_pkg::ST_DWAIT: begin
        if (div_done) state_next = dcomp ? sec_pkg::ST_WB : sec_pkg::ST_DSTART;
      end
      sec_pkg::ST_WB:   state_next = sec_pkg::ST_FETCH;
      sec_pkg::ST_DONE: if (out_go) state_next = sec_pkg::ST_IDLE;
      default: state_next = sec_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready = 1'b0;
    div_start = 1'b0;
    case (state)
      sec_pkg::ST_IDLE:   s_tready = 1'b1;
      sec_pkg::ST_DSTART: div_start = 1'b1;
      default: begin
        s_tready = 1'b0;
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sec_pkg::ST_IDLE;
      kind     <= 1'b0;
      imp.re   <= sec_pkg::word_t'(1 << sec_pkg::FB);
      imp.im   <= '0;
      src      <= '0;
      m_tvalid <= 1'b0;
      err      <= sec_pkg::ERR_OK;
    end else begin
      state <= state_next;
      if (state == sec_pkg::ST_DONE && out_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        sec_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            cmdr <= s_tuser[2:0];
            ek   <= s_tuser[3];
            rez  <= {s_tdata[DW-1:0], s_tdata[2*DW-1:DW]};
            rec  <= {s_tdata[3*DW-1:2*DW], s_tdata[4*DW-1:3*DW]};
            rdr  <= {s_tdata[5*DW-1:4*DW], s_tdata[6*DW-1:5*DW]};
            rz   <= imp;
            rc   <= src;
            ra   <= '0;
          end
        end
        sec_pkg::ST_DECODE: begin
          prog <= dec_prog;
          err  <= dec_err;
          wk   <= dec_wk;
          pc   <= '0;
        end
        sec_pkg::ST_FETCH: begin
          cur   <= uop_f;
          pc    <= pc + 3'd1;
          mcnt  <= '0;
          acc0  <= '0;
          acc1  <= '0;
          acc2  <= '0;
          dcomp <= 1'b0;
        end
        sec_pkg::ST_ADD: begin
          if (cur.op == sec_pkg::OP_SUB) begin
            resv.re <= sec_pkg::sat_dw(sec_pkg::sx(opa.re) - sec_pkg::sx(opb.re));
            resv.im <= sec_pkg::sat_dw(sec_pkg::sx(opa.im) - sec_pkg::sx(opb.im));
          end else begin
            resv.re <= sec_pkg::sat_dw(sec_pkg::sx(opa.re) + sec_pkg::sx(opb.re));
            resv.im <= sec_pkg::sat_dw(sec_pkg::sx(opa.im) + sec_pkg::sx(opb.im));
          end
        end
        sec_pkg::ST_MAC: begin
          mcnt <= mcnt + 3'd1;
          if (mcnt != 3'd0) begin
            if (cur.op == sec_pkg::OP_MUL) begin
              // partial products floored before they are summed
              case (midx)
                3'd0: acc0 <= acc0 + sh;
                3'd1: acc0 <= acc0 - sh;
                default: acc1 <= acc1 + sh;
              endcase
            end else begin
              case (midx)
                3'd0, 3'd1: acc2 <= acc2 + prod;
                3'd2, 3'd3: acc0 <= acc0 + prod;
                3'd4: acc1 <= acc1 + prod;
                default: acc1 <= acc1 - prod;
              endcase
            end
          end
        end
        sec_pkg::ST_DCHK: begin
          if (acc2 == '0) err <= sec_pkg::ERR_DIV0;
        end
        sec_pkg::ST_DSTART: dneg <= dneg_c;
        sec_pkg::ST_DWAIT: begin
          if (div_done) begin
            if (dcomp) resv.im <= dval;
            else resv.re <= dval;
            dcomp <= 1'b1;
          end
        end
        sec_pkg::ST_WB: begin
          case (cur.dst)
            sec_pkg::R_Z: rz <= wbv;
            sec_pkg::R_C: rc <= wbv;
            sec_pkg::R_T: rt <= wbv;
            sec_pkg::R_S: rs <= wbv;
            sec_pkg::R_N: rn <= wbv;
            sec_pkg::R_A: ra <= wbv;
            default: ra <= ra;
          endcase
        end
        sec_pkg::ST_DONE: begin
          if (out_go) begin
            kind     <= nk;
            imp      <= nz;
            src      <= nc;
            if (err == sec_pkg::ERR_OK) begin
              m_tdata <= {ra.im, ra.re, nc.im, nc.re, nz.im, nz.re};
            end else begin
              m_tdata <= {{(2*DW){1'b0}}, nc.im, nc.re, nz.im, nz.re};
            end
            m_tuser <= {err, (!nk && nc == '0), (nk && nz == '0), nk};
          end
        end
        default: cur <= cur;
      endcase
    end
  end

endmodule

// File: rtl/sec_check.sv
// port-level checks for the equivalent source combiner, bound to the top level
// depends on sec_pkg and source_equivalent_combiner_unit
module sec_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [sec_pkg::IN_W-1:0]      m_tdata,
  input logic [sec_pkg::OUT_UW-1:0]    m_tuser
);

  // one transaction at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // fixed voltage only on an emf, fixed current only on a current source
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[1] && !m_tuser[0]) && !(m_tuser[2] && m_tuser[0]))
    else $error("fixed flag disagrees with kind");

  a_err_ans: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[5:3] != sec_pkg::ERR_OK) |->
      m_tdata[sec_pkg::IN_W-1:4*sec_pkg::DW] == '0)
    else $error("answer not cleared on error");

endmodule

bind source_equivalent_combiner_unit sec_check u_sec_check (.*);
